// File: rtl/core/qls_pkg.sv
// shared types, constants and helpers for the queue of linked stacks
package qls_pkg;

  // sizes
  localparam int unsigned POOL_NODES  = 64;
  localparam int unsigned QUEUE_SLOTS = 16;
  localparam int unsigned DATA_W      = 32;
  localparam int unsigned OP_W        = 3;
  localparam int unsigned STATUS_W    = 3;

  // derived widths
  localparam int unsigned NW = $clog2(POOL_NODES);        // node index
  localparam int unsigned LW = $clog2(POOL_NODES + 1);    // link, includes null
  localparam int unsigned SW = $clog2(QUEUE_SLOTS);       // slot index
  localparam int unsigned CW = $clog2(QUEUE_SLOTS + 1);   // stack count

  // null link code
  localparam logic [LW-1:0] NIL = LW'(POOL_NODES);

  // item ops
  typedef enum logic [OP_W-1:0] {
    OP_NEW        = 3'd0,
    OP_PUSH_TAIL  = 3'd1,
    OP_PUSH_HEAD  = 3'd2,
    OP_POP        = 3'd3,
    OP_CLEAR      = 3'd4,
    OP_DEQ        = 3'd5,
    OP_CLEAR_ALL  = 3'd6,
    OP_DUMP       = 3'd7
  } op_e;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK         = 3'd0,
    ST_Q_EMPTY    = 3'd1,
    ST_S_EMPTY    = 3'd2,
    ST_Q_FULL     = 3'd3,
    ST_POOL_EMPTY = 3'd4
  } status_e;

  // control states
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_DUMP
  } state_e;

  // one node of the pool
  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [LW-1:0]     link;
  } node_t;

  // node memory request
  typedef struct packed {
    logic          rd_en;
    logic [NW-1:0] rd_addr;
    logic          wr_en;
    logic [NW-1:0] wr_addr;
    node_t         wr_data;
    logic          clr;
  } node_req_t;

  // one stack descriptor
  typedef struct packed {
    logic [LW-1:0] top;
    logic [LW-1:0] bottom;
  } stk_ent_t;

  // stack memory request
  typedef struct packed {
    logic          rd_en;
    logic [SW-1:0] rd_addr;
    logic          wr_en;
    logic [SW-1:0] wr_addr;
    stk_ent_t      wr_data;
  } stk_req_t;

  // a link that names a real node
  function automatic logic is_node(logic [LW-1:0] l);
    return l < NIL;
  endfunction

  // wrap a slot sum that stays below twice the slot count
  function automatic logic [SW-1:0] slot_wrap(logic [CW:0] sum);
    logic [CW:0] r;
    r = (sum >= (CW+1)'(QUEUE_SLOTS)) ? sum - (CW+1)'(QUEUE_SLOTS) : sum;
    return r[SW-1:0];
  endfunction

endpackage

// File: rtl/core/qls_node_ram.sv
// node pool memory with per-node link valid bits for the reset chain
module qls_node_ram (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qls_pkg::node_req_t req_i,
  output qls_pkg::node_t    rd_o
);

  qls_pkg::node_t                mem_q [qls_pkg::POOL_NODES];
  qls_pkg::node_t                rd_q;
  logic [qls_pkg::POOL_NODES-1:0] vld_q;
  logic                          rd_vld_q;
  logic [qls_pkg::NW-1:0]        rd_addr_q;

  // memory array, registered read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  // link valid bits, cleared by reset and by clear all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q     <= '0;
      rd_vld_q  <= 1'b0;
      rd_addr_q <= '0;
    end else begin
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.wr_en) begin
        vld_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_vld_q  <= vld_q[req_i.rd_addr];
        rd_addr_q <= req_i.rd_addr;
      end
    end
  end

  // an unwritten node links to the next one, the last one to null
  assign rd_o.data = rd_q.data;
  assign rd_o.link = rd_vld_q ? rd_q.link
                              : qls_pkg::LW'(rd_addr_q) + qls_pkg::LW'(1);

endmodule

// File: rtl/core/qls_stack_ram.sv
// stack descriptor memory, top and bottom node per queue slot
module qls_stack_ram (
  input  logic               clk_i,
  input  qls_pkg::stk_req_t  req_i,
  output qls_pkg::stk_ent_t  rd_o
);

  qls_pkg::stk_ent_t mem_q [qls_pkg::QUEUE_SLOTS];
  qls_pkg::stk_ent_t rd_q;

  // memory array, registered read that holds when not read
  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_o = rd_q;

endmodule

// File: rtl/core/qls_ctrl.sv
// op sequencer: queue pointers, free list head, list walks and result register
module qls_ctrl (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic signed [qls_pkg::DATA_W-1:0] s_axis_tdata_i,  // value
  input  logic [qls_pkg::OP_W-1:0]          s_axis_tuser_i,  // op
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic signed [qls_pkg::DATA_W-1:0] m_axis_tdata_o,  // data
  output logic [qls_pkg::STATUS_W-1:0]      m_axis_tuser_o,  // status
  output logic                              m_axis_tlast_o,  // last
  output qls_pkg::node_req_t                node_req_o,
  input  qls_pkg::node_t                    node_rd_i,
  output qls_pkg::stk_req_t                 stk_req_o,
  input  qls_pkg::stk_ent_t                 stk_rd_i
);

  qls_pkg::state_e             state_q, state_d;
  qls_pkg::op_e                op_q;
  logic [qls_pkg::DATA_W-1:0]  value_q;
  logic [qls_pkg::SW-1:0]      slot_q;
  logic [qls_pkg::SW-1:0]      head_q, head_d;
  logic [qls_pkg::CW-1:0]      count_q, count_d;
  logic [qls_pkg::LW-1:0]      free_q, free_d;
  logic [qls_pkg::NW-1:0]      k_q, k_d;

  logic                        out_valid_q;
  logic [qls_pkg::DATA_W-1:0]  out_data_q;
  qls_pkg::status_e            out_status_q;
  logic                        out_last_q;

  logic                        in_accept, out_free;
  logic                        q_empty, q_full, top_node, link_node, free_node, dump_last;
  logic [qls_pkg::CW-1:0]      tail_off;
  logic [qls_pkg::SW-1:0]      cur_tail, new_tail, in_slot;
  qls_pkg::op_e                in_op;
  qls_pkg::stk_ent_t           stk_nil;

  logic                        emit;
  qls_pkg::status_e            emit_status;
  logic [qls_pkg::DATA_W-1:0]  emit_data;
  logic                        emit_last;

  // handshake and condition terms
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !out_valid_q || m_axis_tready_i;
  assign q_empty   = (count_q == '0);
  assign q_full    = (count_q == qls_pkg::CW'(qls_pkg::QUEUE_SLOTS));
  assign top_node  = qls_pkg::is_node(stk_rd_i.top);
  assign link_node = qls_pkg::is_node(node_rd_i.link);
  assign free_node = qls_pkg::is_node(free_q);
  assign dump_last = !link_node || (k_q == qls_pkg::NW'(qls_pkg::POOL_NODES - 1));
  assign stk_nil   = '{top: qls_pkg::NIL, bottom: qls_pkg::NIL};

  // slot of the tail stack and of a new stack
  assign tail_off = q_empty ? '0 : count_q - qls_pkg::CW'(1);
  assign cur_tail = qls_pkg::slot_wrap((qls_pkg::CW+1)'(head_q) + (qls_pkg::CW+1)'(tail_off));
  assign new_tail = qls_pkg::slot_wrap((qls_pkg::CW+1)'(head_q) + (qls_pkg::CW+1)'(count_q));
  assign in_op    = qls_pkg::op_e'(s_axis_tuser_i);
  assign in_slot  = (in_op == qls_pkg::OP_PUSH_TAIL) ? cur_tail : head_q;

  assign s_axis_tready_o = (state_q == qls_pkg::S_IDLE);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qls_pkg::S_IDLE: begin
        if (in_accept) begin
          state_d = qls_pkg::S_EXEC;
        end
      end
      qls_pkg::S_EXEC: begin
        if (out_free) begin
          if (op_q == qls_pkg::OP_POP && !q_empty && top_node) begin
            state_d = qls_pkg::S_POP;
          end else if (op_q == qls_pkg::OP_DUMP && !q_empty && top_node) begin
            state_d = qls_pkg::S_DUMP;
          end else begin
            state_d = qls_pkg::S_IDLE;
          end
        end
      end
      qls_pkg::S_POP: begin
        if (out_free) begin
          state_d = qls_pkg::S_IDLE;
        end
      end
      qls_pkg::S_DUMP: begin
        if (out_free && dump_last) begin
          state_d = qls_pkg::S_IDLE;
        end
      end
      default: state_d = qls_pkg::S_IDLE;
    endcase
  end

  // memory requests, pointer updates and results
  always_comb begin
    node_req_o  = '0;
    stk_req_o   = '0;
    emit        = 1'b0;
    emit_status = qls_pkg::ST_OK;
    emit_data   = '0;
    emit_last   = 1'b1;
    head_d      = head_q;
    count_d     = count_q;
    free_d      = free_q;
    k_d         = k_q;
    case (state_q)
      qls_pkg::S_IDLE: begin
        // fetch the target stack and the free head node
        if (in_accept) begin
          stk_req_o.rd_en    = 1'b1;
          stk_req_o.rd_addr  = in_slot;
          node_req_o.rd_en   = 1'b1;
          node_req_o.rd_addr = free_q[qls_pkg::NW-1:0];
        end
      end
      qls_pkg::S_EXEC: begin
        if (out_free) begin
          emit = 1'b1;
          if (op_q == qls_pkg::OP_NEW) begin
            if (q_full) begin
              emit_status = qls_pkg::ST_Q_FULL;
            end else begin
              stk_req_o.wr_en   = 1'b1;
              stk_req_o.wr_addr = new_tail;
              stk_req_o.wr_data = stk_nil;
              count_d           = count_q + qls_pkg::CW'(1);
            end
          end else if (q_empty) begin
            emit_status = qls_pkg::ST_Q_EMPTY;
          end else begin
            case (op_q)
              qls_pkg::OP_PUSH_TAIL, qls_pkg::OP_PUSH_HEAD: begin
                if (!free_node) begin
                  emit_status = qls_pkg::ST_POOL_EMPTY;
                end else begin
                  // take the free head node as the new top
                  node_req_o.wr_en        = 1'b1;
                  node_req_o.wr_addr      = free_q[qls_pkg::NW-1:0];
                  node_req_o.wr_data.data = value_q;
                  node_req_o.wr_data.link = stk_rd_i.top;
                  free_d                  = node_rd_i.link;
                  stk_req_o.wr_en         = 1'b1;
                  stk_req_o.wr_addr       = slot_q;
                  stk_req_o.wr_data.top   = free_q;
                  stk_req_o.wr_data.bottom = top_node ? stk_rd_i.bottom : free_q;
                end
              end
              qls_pkg::OP_POP: begin
                if (!top_node) begin
                  emit_status = qls_pkg::ST_S_EMPTY;
                end else begin
                  emit               = 1'b0;
                  node_req_o.rd_en   = 1'b1;
                  node_req_o.rd_addr = stk_rd_i.top[qls_pkg::NW-1:0];
                end
              end
              qls_pkg::OP_CLEAR, qls_pkg::OP_DEQ: begin
                // splice the whole list onto the free list via its bottom node
                if (top_node) begin
                  node_req_o.wr_en        = 1'b1;
                  node_req_o.wr_addr      = stk_rd_i.bottom[qls_pkg::NW-1:0];
                  node_req_o.wr_data.data = '0;
                  node_req_o.wr_data.link = free_q;
                  free_d                  = stk_rd_i.top;
                end
                stk_req_o.wr_en   = 1'b1;
                stk_req_o.wr_addr = slot_q;
                stk_req_o.wr_data = stk_nil;
                if (op_q == qls_pkg::OP_DEQ) begin
                  head_d  = qls_pkg::slot_wrap((qls_pkg::CW+1)'(head_q) + (qls_pkg::CW+1)'(1));
                  count_d = count_q - qls_pkg::CW'(1);
                end
              end
              qls_pkg::OP_CLEAR_ALL: begin
                // every node goes back to the reset chain
                node_req_o.clr = 1'b1;
                free_d         = '0;
                head_d         = '0;
                count_d        = '0;
              end
              qls_pkg::OP_DUMP: begin
                if (!top_node) begin
                  emit_status = qls_pkg::ST_S_EMPTY;
                end else begin
                  emit               = 1'b0;
                  node_req_o.rd_en   = 1'b1;
                  node_req_o.rd_addr = stk_rd_i.top[qls_pkg::NW-1:0];
                  k_d                = '0;
                end
              end
              default: ;
            endcase
          end
        end
      end
      qls_pkg::S_POP: begin
        if (out_free) begin
          emit                    = 1'b1;
          emit_data               = node_rd_i.data;
          stk_req_o.wr_en         = 1'b1;
          stk_req_o.wr_addr       = slot_q;
          stk_req_o.wr_data.top   = link_node ? node_rd_i.link : qls_pkg::NIL;
          stk_req_o.wr_data.bottom = stk_rd_i.bottom;
          node_req_o.wr_en        = 1'b1;
          node_req_o.wr_addr      = stk_rd_i.top[qls_pkg::NW-1:0];
          node_req_o.wr_data.data = '0;
          node_req_o.wr_data.link = free_q;
          free_d                  = stk_rd_i.top;
        end
      end
      qls_pkg::S_DUMP: begin
        // one node per cycle while the output register is free, next read follows the link just returned
        if (out_free) begin
          emit      = 1'b1;
          emit_data = node_rd_i.data;
          emit_last = dump_last;
          if (!dump_last) begin
            node_req_o.rd_en   = 1'b1;
            node_req_o.rd_addr = node_rd_i.link[qls_pkg::NW-1:0];
            k_d                = k_q + qls_pkg::NW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qls_pkg::S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      free_q      <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      free_q  <= free_d;
      k_q     <= k_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // item capture and result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= in_op;
      value_q <= s_axis_tdata_i;
      slot_q  <= in_slot;
    end
    if (emit) begin
      out_status_q <= emit_status;
      out_data_q   <= emit_data;
      out_last_q   <= emit_last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

// File: rtl/core/queue_of_linked_stacks.sv
// top level of the queue of linked stacks
// A FIFO of up to 16 stacks whose entries live in a shared pool of 64 nodes
// (node memory plus a stack descriptor memory, both with registered synchronous
// reads). Each stack descriptor keeps its top and bottom node, so clearing or
// dequeuing a stack splices it onto the free list in one step, and clear all
// restores the whole pool at once; no clearing pass is needed after reset.
// An item is accepted, then executed once the descriptor and free-head node
// reads return; a pop then reads the top node after the descriptor; a dump
// emits one result per node, one result per cycle while the output register
// is free, following the link returned by the node memory. Any step that
// produces a result waits while the output register is still full.
module queue_of_linked_stacks (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic signed [qls_pkg::DATA_W-1:0] s_axis_tdata_i,  // value
  input  logic [qls_pkg::OP_W-1:0]          s_axis_tuser_i,  // op
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic signed [qls_pkg::DATA_W-1:0] m_axis_tdata_o,  // data
  output logic [qls_pkg::STATUS_W-1:0]      m_axis_tuser_o,  // status
  output logic                              m_axis_tlast_o   // last
);

  qls_pkg::node_req_t node_req;
  qls_pkg::node_t     node_rd;
  qls_pkg::stk_req_t  stk_req;
  qls_pkg::stk_ent_t  stk_rd;

  // sequencer
  qls_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o),
    .node_req_o      (node_req),
    .node_rd_i       (node_rd),
    .stk_req_o       (stk_req),
    .stk_rd_i        (stk_rd)
  );

  // node pool
  qls_node_ram u_node_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (node_req),
    .rd_o   (node_rd)
  );

  // stack descriptors
  qls_stack_ram u_stack_ram (
    .clk_i (clk_i),
    .req_i (stk_req),
    .rd_o  (stk_rd)
  );

`ifndef SYNTHESIS
  // any error result closes its item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o != qls_pkg::ST_OK) |-> m_axis_tlast_o)
    else $error("error status without last");

  // only a successful pop or dump carries a data word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o != '0) |-> (m_axis_tuser_o == qls_pkg::ST_OK))
    else $error("data word with error status");

  // one item at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("item accepted while busy");
`endif

endmodule
